// ----- rtl/ypcb_pkg.sv -----
// ypcb_pkg: shared types, constants and functions of the camera basis unit
// no dependencies
package ypcb_pkg;

  localparam int CordicSteps   = 16;
  localparam int AngleFracBits = 7;
  localparam int AtanEntries   = 24;
  localparam int StepW         = 5;

  localparam logic signed [33:0] CordicGain = 34'sd652032874;
  localparam logic [24:0]        DegToRad   = 25'd18740330;
  localparam logic signed [16:0] HalfTurn   = 17'sd180 <<< AngleFracBits;
  localparam logic signed [16:0] PitchLim   = 17'sd89 <<< AngleFracBits;
  localparam logic [15:0]        QuarterU   = 16'd90 << AngleFracBits;
  localparam logic [15:0]        HalfU      = 16'd180 << AngleFracBits;

  typedef enum logic [2:0] {
    REQ_TURN  = 3'd0,
    REQ_SETV  = 3'd1,
    REQ_LACC  = 3'd2,
    REQ_WACC  = 3'd3,
    REQ_QUERY = 3'd4
  } req_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ANGLE, ST_CYAW, ST_CPITCH, ST_BASIS1, ST_BASIS2,
    ST_LOC0, ST_LOC1, ST_LOC2, ST_VEL, ST_OUT
  } state_e;

  typedef struct packed {
    logic load;      // latch input item
    logic turn;      // update angles
    logic cstart;    // load cordic from angle
    logic csel;      // 0 yaw, 1 pitch
    logic citer;     // one cordic iteration
    logic cstore;    // store cordic result
    logic basis1;
    logic basis2;
    logic [1:0] loc_sel;
    logic loc_en;
    logic vel_en;
  } ypcb_cmd_t;

  typedef struct packed {
    logic cdone;
  } ypcb_sts_t;

  function automatic logic signed [33:0] atan_q30(input logic [StepW-1:0] i);
    case (i)
      5'd0:  atan_q30 = 34'sd843314856;
      5'd1:  atan_q30 = 34'sd497837829;
      5'd2:  atan_q30 = 34'sd263043836;
      5'd3:  atan_q30 = 34'sd133525158;
      5'd4:  atan_q30 = 34'sd67021686;
      5'd5:  atan_q30 = 34'sd33543515;
      5'd6:  atan_q30 = 34'sd16775850;
      5'd7:  atan_q30 = 34'sd8388437;
      5'd8:  atan_q30 = 34'sd4194282;
      5'd9:  atan_q30 = 34'sd2097149;
      5'd10: atan_q30 = 34'sd1048575;
      5'd11: atan_q30 = 34'sd524287;
      5'd12: atan_q30 = 34'sd262143;
      5'd13: atan_q30 = 34'sd131071;
      5'd14: atan_q30 = 34'sd65535;
      5'd15: atan_q30 = 34'sd32767;
      5'd16: atan_q30 = 34'sd16383;
      5'd17: atan_q30 = 34'sd8191;
      5'd18: atan_q30 = 34'sd4095;
      5'd19: atan_q30 = 34'sd2047;
      5'd20: atan_q30 = 34'sd1023;
      5'd21: atan_q30 = 34'sd511;
      5'd22: atan_q30 = 34'sd255;
      5'd23: atan_q30 = 34'sd127;
      default: atan_q30 = '0;
    endcase
  endfunction

  // round half up from q30 to q14, clamp to +-1
  function automatic logic signed [15:0] rnd_q14(input logic signed [33:0] v);
    logic signed [34:0] t;
    t = ($signed({v[33], v}) + 35'sd32768) >>> 16;
    if (t > 35'sd16384) rnd_q14 = 16'sd16384;
    else if (t < -35'sd16384) rnd_q14 = -16'sd16384;
    else rnd_q14 = t[15:0];
  endfunction

  function automatic logic signed [15:0] mul14(input logic signed [15:0] a,
                                               input logic signed [15:0] b);
    logic signed [31:0] p;
    p = (a * b + 32'sd8192) >>> 14;
    if (p > 32'sd16384) mul14 = 16'sd16384;
    else if (p < -32'sd16384) mul14 = -16'sd16384;
    else mul14 = p[15:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    if (v > 50'sd2147483647) sat32 = 32'h7fffffff;
    else if (v < -50'sd2147483648) sat32 = 32'h80000000;
    else sat32 = v[31:0];
  endfunction

endpackage

// ----- rtl/ypcb_ctrl.sv -----
// ypcb_ctrl: sequencer of the camera basis unit
// depends on ypcb_pkg
module ypcb_ctrl import ypcb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  input  ypcb_sts_t sts_i,
  output ypcb_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_ANGLE;
      ST_ANGLE:  state_d = ST_CYAW;
      ST_CYAW:   if (sts_i.cdone) state_d = ST_CPITCH;
      ST_CPITCH: if (sts_i.cdone) state_d = ST_BASIS1;
      ST_BASIS1: state_d = ST_BASIS2;
      ST_BASIS2: state_d = ST_LOC0;
      ST_LOC0:   state_d = ST_LOC1;
      ST_LOC1:   state_d = ST_LOC2;
      ST_LOC2:   state_d = ST_VEL;
      ST_VEL:    state_d = ST_OUT;
      ST_OUT:    if (!out_stall_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_stall_o = (state_q != ST_IDLE);
    out_valid_o = (state_q == ST_OUT);
    case (state_q)
      ST_IDLE:   cmd_o.load = in_valid_i;
      ST_ANGLE:  begin cmd_o.turn = 1'b1; end
      ST_CYAW:   begin
        cmd_o.citer = !sts_i.cdone;
        cmd_o.cstore = sts_i.cdone;
      end
      ST_CPITCH: begin
        cmd_o.csel = 1'b1;
        cmd_o.citer = !sts_i.cdone;
        cmd_o.cstore = sts_i.cdone;
      end
      ST_BASIS1: cmd_o.basis1 = 1'b1;
      ST_BASIS2: cmd_o.basis2 = 1'b1;
      ST_LOC0:   begin cmd_o.loc_en = 1'b1; cmd_o.loc_sel = 2'd0; end
      ST_LOC1:   begin cmd_o.loc_en = 1'b1; cmd_o.loc_sel = 2'd1; end
      ST_LOC2:   begin cmd_o.loc_en = 1'b1; cmd_o.loc_sel = 2'd2; end
      ST_VEL:    cmd_o.vel_en = 1'b1;
      default:   cmd_o = '0;
    endcase
    // cordic start when entering a sine/cosine pass
    cmd_o.cstart = (state_q == ST_ANGLE) || (state_q == ST_CYAW && sts_i.cdone);
  end

endmodule

// ----- rtl/ypcb_dp.sv -----
// ypcb_dp: angle, cordic, basis and velocity datapath
// depends on ypcb_pkg
module ypcb_dp import ypcb_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ypcb_cmd_t          cmd_i,
  output ypcb_sts_t          sts_o,
  input  logic [2:0]         req_type_i,
  input  logic signed [15:0] delta_yaw_i,
  input  logic signed [15:0] delta_pitch_i,
  input  logic signed [31:0] vec_x_i,
  input  logic signed [31:0] vec_y_i,
  input  logic signed [31:0] vec_z_i,
  output logic signed [15:0] front_x_o,
  output logic signed [15:0] front_y_o,
  output logic signed [15:0] front_z_o,
  output logic signed [15:0] right_x_o,
  output logic signed [15:0] right_z_o,
  output logic signed [15:0] up_x_o,
  output logic signed [15:0] up_y_o,
  output logic signed [15:0] up_z_o,
  output logic signed [31:0] vel_x_o,
  output logic signed [31:0] vel_y_o,
  output logic signed [31:0] vel_z_o
);

  logic [2:0] req_q;
  logic signed [15:0] dyaw_q, dpitch_q;
  logic signed [31:0] vec_q [3];
  logic signed [15:0] yaw_q, pitch_q;
  logic signed [31:0] vel_q [3];

  logic signed [33:0] cx_q, cy_q, cz_q;
  logic [StepW-1:0] cnt_q;
  logic sneg_q, cneg_q;
  logic signed [15:0] sy_q, cy2_q, sp_q, cp_q;
  logic signed [15:0] fx_q, fz_q, ux_q, uy_q, uz_q;
  logic signed [49:0] loc_q [3];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_type_i;
      dyaw_q <= delta_yaw_i;
      dpitch_q <= delta_pitch_i;
      vec_q[0] <= vec_x_i;
      vec_q[1] <= vec_y_i;
      vec_q[2] <= vec_z_i;
    end
  end

  // turn: yaw wraps once, pitch clamps
  logic signed [16:0] yaw_sum, yaw_w, p_sum, p_c;
  always_comb begin
    yaw_sum = {yaw_q[15], yaw_q} + {dyaw_q[15], dyaw_q};
    if (yaw_sum < -HalfTurn) yaw_w = yaw_sum + (HalfTurn <<< 1);
    else if (yaw_sum > HalfTurn) yaw_w = yaw_sum - (HalfTurn <<< 1);
    else yaw_w = yaw_sum;
    p_sum = {pitch_q[15], pitch_q} + {dpitch_q[15], dpitch_q};
    if (p_sum > PitchLim) p_c = PitchLim;
    else if (p_sum < -PitchLim) p_c = -PitchLim;
    else p_c = p_sum;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      yaw_q <= '0;
      pitch_q <= '0;
      vel_q[0] <= '0;
      vel_q[1] <= '0;
      vel_q[2] <= '0;
    end else begin
      if (cmd_i.turn && req_q == REQ_TURN) begin
        yaw_q <= yaw_w[15:0];
        pitch_q <= p_c[15:0];
      end
      if (cmd_i.vel_en) begin
        for (int k = 0; k < 3; k++) begin
          case (req_q)
            REQ_SETV: vel_q[k] <= sat32(loc_q[k]);
            REQ_LACC: vel_q[k] <= sat32(loc_q[k] + 50'(vel_q[k]));
            REQ_WACC: vel_q[k] <= sat32(50'(vel_q[k]) + 50'(vec_q[k]));
            default:  vel_q[k] <= vel_q[k];
          endcase
        end
      end
    end
  end

  // angle fold to [0, 90] degrees; yaw in the turn cycle (taken after the
  // turn update), pitch for the start at the end of the yaw pass
  logic signed [15:0] ang;
  logic [15:0] u0, u1, u2;
  logic [40:0] zprod;
  always_comb begin
    ang = cmd_i.turn ? ((req_q == REQ_TURN) ? yaw_w[15:0] : yaw_q) : pitch_q;
    u0 = ang[15] ? 16'(-ang) : 16'(ang);
    u1 = (u0 > HalfU) ? HalfU : u0;
    u2 = (u1 > QuarterU) ? HalfU - u1 : u1;
    zprod = (41'(u2) * 41'(DegToRad)) >> AngleFracBits;
  end

  logic signed [33:0] ax, ay;
  assign ax = cx_q >>> cnt_q;
  assign ay = cy_q >>> cnt_q;
  assign sts_o.cdone = (cnt_q == StepW'(CordicSteps));

  always_ff @(posedge clk_i) begin
    if (cmd_i.cstart) begin
      cx_q <= CordicGain;
      cy_q <= '0;
      cz_q <= 34'(zprod);
      cnt_q <= '0;
      sneg_q <= ang[15];
      cneg_q <= (u1 > QuarterU);
    end else if (cmd_i.citer) begin
      if (!cz_q[33]) begin
        cx_q <= cx_q - ay;
        cy_q <= cy_q + ax;
        cz_q <= cz_q - atan_q30(cnt_q);
      end else begin
        cx_q <= cx_q + ay;
        cy_q <= cy_q - ax;
        cz_q <= cz_q + atan_q30(cnt_q);
      end
      cnt_q <= cnt_q + 1'b1;
    end
    if (cmd_i.cstore) begin
      if (cmd_i.csel) begin
        sp_q <= sneg_q ? -rnd_q14(cy_q) : rnd_q14(cy_q);
        cp_q <= cneg_q ? -rnd_q14(cx_q) : rnd_q14(cx_q);
      end else begin
        sy_q <= sneg_q ? -rnd_q14(cy_q) : rnd_q14(cy_q);
        cy2_q <= cneg_q ? -rnd_q14(cx_q) : rnd_q14(cx_q);
      end
    end
    if (cmd_i.basis1) begin
      fx_q <= mul14(cy2_q, cp_q);
      fz_q <= mul14(sy_q, cp_q);
      ux_q <= -mul14(cy2_q, sp_q);
      uz_q <= mul14(-sy_q, sp_q);
    end
  end

  logic signed [16:0] uy_w;
  always_comb begin
    uy_w = 17'(mul14(cy2_q, fx_q)) - 17'(mul14(-sy_q, fz_q));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.basis2) begin
      if (uy_w > 17'sd16384) uy_q <= 16'sd16384;
      else if (uy_w < -17'sd16384) uy_q <= -16'sd16384;
      else uy_q <= uy_w[15:0];
    end
  end

  // local mapping, one component per cycle
  logic signed [15:0] m0, m1, m2;
  logic signed [49:0] lsum;
  always_comb begin
    case (cmd_i.loc_sel)
      2'd0: begin m0 = -sy_q;  m1 = ux_q; m2 = fx_q; end
      2'd1: begin m0 = 16'sd0; m1 = uy_q; m2 = sp_q; end
      2'd2: begin m0 = cy2_q;  m1 = uz_q; m2 = fz_q; end
      default: begin m0 = '0; m1 = '0; m2 = '0; end
    endcase
    lsum = 50'(vec_q[0]) * 50'(m0) + 50'(vec_q[1]) * 50'(m1)
           - 50'(vec_q[2]) * 50'(m2) + 50'sd8192;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.loc_en) loc_q[cmd_i.loc_sel] <= lsum >>> 14;
  end

  assign front_x_o = fx_q;
  assign front_y_o = sp_q;
  assign front_z_o = fz_q;
  assign right_x_o = -sy_q;
  assign right_z_o = cy2_q;
  assign up_x_o = ux_q;
  assign up_y_o = uy_q;
  assign up_z_o = uz_q;
  assign vel_x_o = vel_q[0];
  assign vel_y_o = vel_q[1];
  assign vel_z_o = vel_q[2];

endmodule

// ----- rtl/yaw_pitch_camera_basis_top.sv -----
// yaw_pitch_camera_basis_top: top level of the camera basis unit
// depends on ypcb_pkg, ypcb_ctrl, ypcb_dp
// one item at a time, in order: an angle update, two 16-step cordic passes
// on one shared rotator (yaw then pitch), the basis1 and basis2 multiplies,
// local mapping of the three components and a velocity update; the result is held
// until taken, and the next item is accepted the cycle after
module yaw_pitch_camera_basis_top import ypcb_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         req_type_i,
  input  logic signed [15:0] delta_yaw_i,
  input  logic signed [15:0] delta_pitch_i,
  input  logic signed [31:0] vec_x_i,
  input  logic signed [31:0] vec_y_i,
  input  logic signed [31:0] vec_z_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] front_x_o,
  output logic signed [15:0] front_y_o,
  output logic signed [15:0] front_z_o,
  output logic signed [15:0] right_x_o,
  output logic signed [15:0] right_z_o,
  output logic signed [15:0] up_x_o,
  output logic signed [15:0] up_y_o,
  output logic signed [15:0] up_z_o,
  output logic signed [31:0] vel_x_o,
  output logic signed [31:0] vel_y_o,
  output logic signed [31:0] vel_z_o
);

  ypcb_cmd_t cmd;
  ypcb_sts_t sts;

  // sequencer
  ypcb_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  // arithmetic and state
  ypcb_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .req_type_i, .delta_yaw_i, .delta_pitch_i, .vec_x_i, .vec_y_i, .vec_z_i,
    .front_x_o, .front_y_o, .front_z_o, .right_x_o, .right_z_o,
    .up_x_o, .up_y_o, .up_z_o, .vel_x_o, .vel_y_o, .vel_z_o
  );

endmodule
